[sv/gffrp_pkg.sv]
// ----------------------------------------------------------------------------
// gffrp_pkg: shared types and constants of the grid rectangle placer
// Field widths, register indexes and reset values, the controller states and
// the request and response words of the slot divider.
// ----------------------------------------------------------------------------
package gffrp_pkg;

  localparam int RECT_W     = 13;
  localparam int SLOT_W     = 8;
  localparam int POS_W      = 14;
  localparam int GRID_CFG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_CNT_W  = 4;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_ID_BITS     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT    = 2'd2;

  localparam logic [GRID_CFG_W-1:0] RST_COLUMNS = 7'd64;
  localparam logic [GRID_CFG_W-1:0] RST_ROWS    = 7'd64;
  localparam logic [SLOT_W-1:0]     RST_SLOT    = 8'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_FIT,
    ST_SCAN_PICK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [RECT_W-1:0] dividend;
    logic [SLOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RECT_W-1:0] slots;
  } div_resp_t;

endpackage

[sv/grid_first_fit_rect_placer_top.sv]
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_top: first-fit rectangle placer on a slot grid
//
// The input channel takes one word per rectangle (pixel width, pixel height,
// id) under in_valid / in_stall; the output channel returns one word per
// rectangle (placed, pos_x, pos_y) under out_valid / out_stall. The config
// channel (cfg_valid / cfg_ready, always ready) writes grid_columns, grid_rows
// and slot_size; writes are to go in only while no rectangle is in flight,
// and the block itself does not enforce it. One rectangle is worked at a
// time. Sizing runs in the shared bit-serial divider (13 steps each for
// width and height). The scan then reads ys grid rows per candidate start
// row, one row-memory read a cycle, and evaluates them in SCAN_WAIT,
// SCAN_FIT and SCAN_PICK. Marking reads and then writes back each covered
// row. The row memory, read one row at a time, sets the rate.
// Reset clears the grid at once through per-row valid bits; no clearing pass.
// A finished result waits in the output register while the next rectangle is
// taken; a result that finishes while that register is still stalled holds
// the block until the register frees.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_placer_top #(
  parameter int MAX_COLUMNS = gffrp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gffrp_pkg::DEF_MAX_ROWS,
  parameter int ID_BITS     = gffrp_pkg::DEF_ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gffrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gffrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gffrp_pkg::RECT_W-1:0]      rect_width,
  input  logic [gffrp_pkg::RECT_W-1:0]      rect_height,
  input  logic [ID_BITS-1:0]                rect_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              placed,
  output logic [gffrp_pkg::POS_W-1:0]       pos_x,
  output logic [gffrp_pkg::POS_W-1:0]       pos_y
);
  import gffrp_pkg::*;

  localparam int CC_W = $clog2(MAX_COLUMNS + 1);
  localparam int RC_W = $clog2(MAX_ROWS + 1);
  localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [GRID_CFG_W-1:0] grid_columns;
  logic [GRID_CFG_W-1:0] grid_rows;
  logic [SLOT_W-1:0]     slot_size;
  logic [CC_W-1:0]       cols;
  logic [RC_W-1:0]       rows;
  logic [SLOT_W-1:0]     slot;

  div_req_t  div_req;
  div_resp_t div_resp;

  logic                              mem_rd_en;
  logic [RA_W-1:0]                   mem_rd_addr;
  logic [MAX_COLUMNS-1:0][ID_BITS:0] mem_rd_data;
  logic                              mem_wr_en;
  logic [RA_W-1:0]                   mem_wr_addr;
  logic [MAX_COLUMNS-1:0][ID_BITS:0] mem_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= RST_COLUMNS;
      grid_rows    <= RST_ROWS;
      slot_size    <= RST_SLOT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMNS: grid_columns <= cfg_data[GRID_CFG_W-1:0];
        CFG_ROWS:    grid_rows    <= cfg_data[GRID_CFG_W-1:0];
        CFG_SLOT:    slot_size    <= cfg_data[SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Grid sizes beyond the storage are clipped to it; a zero slot counts as one.
  assign cols = (32'(grid_columns) > MAX_COLUMNS) ? CC_W'(MAX_COLUMNS)
                                                  : CC_W'(grid_columns);
  assign rows = (32'(grid_rows) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(grid_rows);
  assign slot = (slot_size == '0) ? SLOT_W'(1) : slot_size;

  gffrp_ceil_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  gffrp_grid_mem #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .ID_BITS     (ID_BITS)
  ) u_grid (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  gffrp_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_id     (rect_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .placed      (placed),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cols        (cols),
    .rows        (rows),
    .slot        (slot),
    .div_req     (div_req),
    .div_resp    (div_resp),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

[sv/gffrp_ceil_div.sv]
// ----------------------------------------------------------------------------
// gffrp_ceil_div: iterative rounding-up divider
// Restoring division, one quotient bit per cycle, that turns a pixel length
// into a whole number of slots.
// ----------------------------------------------------------------------------
module gffrp_ceil_div (
  input  logic                  clk,
  input  logic                  rst,
  input  gffrp_pkg::div_req_t   req,
  output gffrp_pkg::div_resp_t  resp
);
  import gffrp_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RECT_W-1:0]    num;
  logic [SLOT_W-1:0]    dvs;
  logic [SLOT_W-1:0]    rem;
  logic [SLOT_W:0]      rem_sh;
  logic [SLOT_W-1:0]    rem_step;
  logic                 ge;

  assign rem_sh   = {rem, num[RECT_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  // The remainder stays below the divisor, so it always fits in SLOT_W bits.
  assign rem_step = ge ? SLOT_W'(rem_sh - {1'b0, dvs}) : SLOT_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(RECT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in from the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[RECT_W-2:0], ge};
      rem <= rem_step;
    end
  end

  assign resp.done  = done;
  assign resp.slots = num + RECT_W'(rem != '0);

endmodule

[sv/gffrp_grid_mem.sv]
// ----------------------------------------------------------------------------
// gffrp_grid_mem: occupancy grid storage
// One entry per grid row, holding an occupied bit and an id for every column.
// A per-row valid bit makes a row that was never written read as free.
// ----------------------------------------------------------------------------
module gffrp_grid_mem #(
  parameter int MAX_COLUMNS = gffrp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gffrp_pkg::DEF_MAX_ROWS,
  parameter int ID_BITS     = gffrp_pkg::DEF_ID_BITS,
  localparam int RA_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rd_en,
  input  logic [RA_W-1:0]                      rd_addr,
  output logic [MAX_COLUMNS-1:0][ID_BITS:0]    rd_data,
  input  logic                                 wr_en,
  input  logic [RA_W-1:0]                      wr_addr,
  input  logic [MAX_COLUMNS-1:0][ID_BITS:0]    wr_data
);
  import gffrp_pkg::*;

  logic [MAX_COLUMNS-1:0][ID_BITS:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]               row_valid;
  logic [MAX_COLUMNS-1:0][ID_BITS:0] rd_q;
  logic                              rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[sv/gffrp_ctrl.sv]
// ----------------------------------------------------------------------------
// gffrp_ctrl: placement sequencer
// Sizes the rectangle, scans candidate start rows by ORing the covered grid
// rows, picks the first free column window and marks the rows read-modify-write.
// ----------------------------------------------------------------------------
module gffrp_ctrl #(
  parameter int MAX_COLUMNS = gffrp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gffrp_pkg::DEF_MAX_ROWS,
  parameter int ID_BITS     = gffrp_pkg::DEF_ID_BITS,
  localparam int CC_W       = $clog2(MAX_COLUMNS + 1),
  localparam int RC_W       = $clog2(MAX_ROWS + 1),
  localparam int RA_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gffrp_pkg::RECT_W-1:0]         rect_width,
  input  logic [gffrp_pkg::RECT_W-1:0]         rect_height,
  input  logic [ID_BITS-1:0]                   rect_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 placed,
  output logic [gffrp_pkg::POS_W-1:0]          pos_x,
  output logic [gffrp_pkg::POS_W-1:0]          pos_y,
  input  logic [CC_W-1:0]                      cols,
  input  logic [RC_W-1:0]                      rows,
  input  logic [gffrp_pkg::SLOT_W-1:0]         slot,
  output gffrp_pkg::div_req_t                  div_req,
  input  gffrp_pkg::div_resp_t                 div_resp,
  output logic                                 mem_rd_en,
  output logic [RA_W-1:0]                      mem_rd_addr,
  input  logic [MAX_COLUMNS-1:0][ID_BITS:0]    mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [RA_W-1:0]                      mem_wr_addr,
  output logic [MAX_COLUMNS-1:0][ID_BITS:0]    mem_wr_data
);
  import gffrp_pkg::*;

  localparam int CA_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  state_t state, state_next;

  logic [RECT_W-1:0]      h_reg;
  logic [RECT_W-1:0]      xs;
  logic [RECT_W-1:0]      ys;
  logic [ID_BITS-1:0]     id_reg;
  logic [RC_W-1:0]        r;
  logic [RC_W-1:0]        k;
  logic [CA_W-1:0]        col;
  logic                   found;
  logic                   scan_pend;
  logic [MAX_COLUMNS-1:0] acc;
  logic [MAX_COLUMNS-1:0] xmask;
  logic [MAX_COLUMNS-1:0] xmask_next;
  logic [MAX_COLUMNS-1:0] wmask;
  logic [MAX_COLUMNS-1:0] fit;
  logic [MAX_COLUMNS-1:0] fit_next;
  logic [MAX_COLUMNS-1:0] row_used;
  logic [CA_W-1:0]        first_col;
  logic                   any_fit;
  logic                   in_acc;
  logic                   out_acc;
  logic                   load_out;
  logic                   no_fit;
  logic                   zero_size;
  logic                   last_k;
  logic                   last_r;
  logic [RA_W-1:0]        row_addr;
  logic [CA_W+SLOT_W-1:0] px_full;
  logic [RC_W+SLOT_W-1:0] py_full;
  logic [MAX_COLUMNS-1:0][ID_BITS:0] merged;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign load_out  = !out_valid || !out_stall;

  assign no_fit    = (cols == '0) || (rows == '0) ||
                     (32'(xs) > 32'(cols)) || (32'(ys) > 32'(rows));
  assign zero_size = (xs == '0) || (ys == '0);
  assign last_k    = (32'(k) + 32'd1 == 32'(ys));
  assign last_r    = (32'(r) + 32'(ys) >= 32'(rows));
  assign row_addr  = RA_W'(r + k);

  assign px_full = col * slot;
  assign py_full = r * slot;

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      row_used[c]   = mem_rd_data[c][ID_BITS];
      xmask_next[c] = (32'(c) < 32'(xs));
      fit_next[c]   = ~|(acc & (xmask << c)) && (32'(c) + 32'(xs) <= 32'(cols));
      merged[c]     = wmask[c] ? {1'b1, id_reg} : mem_rd_data[c];
    end
  end

  // Lowest column wins, which keeps the row-major first-fit order.
  always_comb begin
    any_fit   = |fit;
    first_col = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (fit[c]) begin
        first_col = CA_W'(c);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_resp.done) state_next = ST_DIV_H;
      end
      ST_DIV_H: begin
        if (div_resp.done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (no_fit || zero_size) ? ST_FINISH : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (last_k) state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        state_next = ST_SCAN_FIT;
      end
      ST_SCAN_FIT: begin
        state_next = ST_SCAN_PICK;
      end
      ST_SCAN_PICK: begin
        if (any_fit) begin
          state_next = ST_MARK_RD;
        end else if (last_r) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_MARK_RD: begin
        state_next = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        state_next = last_k ? ST_FINISH : ST_MARK_RD;
      end
      ST_FINISH: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Each row is read in one state and written in the next, and no other
  // access falls between, so a read never races a write to the same row.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = h_reg;
    div_req.divisor  = slot;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = row_addr;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = row_addr;
    mem_wr_data      = merged;
    case (state)
      ST_IDLE: begin
        div_req.start    = in_acc;
        div_req.dividend = rect_width;
      end
      ST_DIV_W: begin
        div_req.start = div_resp.done;
      end
      ST_SCAN_RD, ST_MARK_RD: begin
        mem_rd_en = 1'b1;
      end
      ST_MARK_WR: begin
        mem_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_pend <= (state == ST_SCAN_RD);
      if (state == ST_FINISH && load_out) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          h_reg  <= rect_height;
          id_reg <= rect_id;
        end
      end
      ST_DIV_W: begin
        if (div_resp.done) xs <= div_resp.slots;
      end
      ST_DIV_H: begin
        if (div_resp.done) ys <= div_resp.slots;
      end
      ST_CHECK: begin
        xmask <= xmask_next;
        r     <= '0;
        k     <= '0;
        col   <= '0;
        acc   <= '0;
        found <= !no_fit;
      end
      ST_SCAN_RD: begin
        k <= last_k ? '0 : k + RC_W'(1);
      end
      ST_SCAN_FIT: begin
        fit <= fit_next;
      end
      ST_SCAN_PICK: begin
        if (any_fit) begin
          col   <= first_col;
          wmask <= xmask << first_col;
        end else if (last_r) begin
          found <= 1'b0;
        end else begin
          r   <= r + RC_W'(1);
          acc <= '0;
        end
      end
      ST_MARK_WR: begin
        k <= k + RC_W'(1);
      end
      ST_FINISH: begin
        if (load_out) begin
          placed <= found;
          pos_x  <= found ? POS_W'(px_full) : '0;
          pos_y  <= found ? POS_W'(py_full) : '0;
        end
      end
      default: begin
      end
    endcase
    if (scan_pend) begin
      acc <= acc | row_used;
    end
  end

`ifndef NO_ASSERTIONS
  a_rmw_pair: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> ($past(mem_rd_en) && ($past(mem_rd_addr) == mem_wr_addr)))
    else $error("grid write without a read of the same row one cycle earlier");

  a_mark_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK_WR) |-> ((wmask & row_used) == '0))
    else $error("marking a cell that is already occupied");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> ((state == ST_DIV_W) || (state == ST_DIV_H)))
    else $error("divider finished outside a sizing state");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result word loaded outside the finish state");
`endif

endmodule

[tb/grid_first_fit_rect_placer_top_tb.sv]
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_top_tb: self-checking bench for the slot placer
// Rectangles go in through a driver fed from a queue, and placements come
// back through a monitor that stalls at random. Every accepted rectangle is
// placed on a private copy of the occupancy grid. The resulting word is queued
// and compared with the block's output in order. The grid setup is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_placer_top_tb;
  import gffrp_pkg::*;

  localparam int GRID_COLS  = DEF_MAX_COLUMNS;
  localparam int GRID_ROWS  = DEF_MAX_ROWS;
  localparam int TAG_W      = DEF_ID_BITS;
  localparam int CYCLE_CAP  = 3000000;
  localparam int SETTLE     = 50;
  localparam int HOLD_AFTER = 25;
  localparam int HOLD_LEN   = 3000;
  localparam int RECT_MAX   = (1 << RECT_W) - 1;
  // Index 3 selects no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } spot_t;

  typedef struct {
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
    logic [TAG_W-1:0]  id;
    bit                drain;
  } rect_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [RECT_W-1:0]     rect_width;
  logic [RECT_W-1:0]     rect_height;
  logic [TAG_W-1:0]      rect_id;
  logic                  out_valid;
  logic                  out_stall;
  logic                  placed;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;

  grid_first_fit_rect_placer_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .rect_id    (rect_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .placed     (placed),
    .pos_x      (pos_x),
    .pos_y      (pos_y)
  );

  // Private copy of the grid setup and the occupancy grid.
  logic [GRID_CFG_W-1:0] cols_setting;
  logic [GRID_CFG_W-1:0] rows_setting;
  logic [SLOT_W-1:0]     slot_setting;
  bit                    cell_taken [GRID_COLS*GRID_ROWS];
  logic [TAG_W-1:0]      cell_owner [GRID_COLS*GRID_ROWS];
  int                    taken_sum  [GRID_ROWS+1][GRID_COLS+1];

  rect_t pending_rects[$];
  spot_t expected_spots[$];

  int  rects_queued;
  int  rects_taken;
  int  spots_seen;
  int  mismatches;
  int  cycle_count;
  int  send_wait;
  int  recv_wait;
  int  hold_left;
  bit  hold_armed;
  bit  send_idle_on;
  bit  recv_idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int idle_draw(input bit on);
    return on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic int block_sum(input int r, input int c, input int ys, input int xs);
    return taken_sum[r+ys][c+xs] - taken_sum[r][c+xs] - taken_sum[r+ys][c] + taken_sum[r][c];
  endfunction

  // First-fit placement of one rectangle; updates the grid copy when it fits.
  function automatic spot_t place_rect(input logic [RECT_W-1:0] w, input logic [RECT_W-1:0] h,
                                       input logic [TAG_W-1:0] id);
    int    pitch, cols, rows, xs, ys, r, c, fr, fc;
    bit    found;
    spot_t res;
    res = '0;
    found = 0;
    fr = 0;
    fc = 0;
    pitch = (slot_setting == 0) ? 1 : int'(slot_setting);
    cols = (cols_setting > GRID_COLS) ? GRID_COLS : int'(cols_setting);
    rows = (rows_setting > GRID_ROWS) ? GRID_ROWS : int'(rows_setting);
    xs = (int'(w) + pitch - 1) / pitch;
    ys = (int'(h) + pitch - 1) / pitch;
    if (xs > cols || ys > rows) return res;
    for (r = 0; r <= GRID_ROWS; r++) taken_sum[r][0] = 0;
    for (c = 0; c <= GRID_COLS; c++) taken_sum[0][c] = 0;
    for (r = 0; r < GRID_ROWS; r++)
      for (c = 0; c < GRID_COLS; c++)
        taken_sum[r+1][c+1] = taken_sum[r][c+1] + taken_sum[r+1][c] - taken_sum[r][c]
                              + (cell_taken[r*GRID_COLS+c] ? 1 : 0);
    for (r = 0; r < rows && r + ys <= rows && !found; r++)
      for (c = 0; c < cols && c + xs <= cols && !found; c++)
        if (block_sum(r, c, ys, xs) == 0) begin
          found = 1;
          fr = r;
          fc = c;
        end
    if (!found) return res;
    for (r = 0; r < ys; r++)
      for (c = 0; c < xs; c++) begin
        cell_taken[(fr+r)*GRID_COLS + fc + c] = 1;
        cell_owner[(fr+r)*GRID_COLS + fc + c] = id;
      end
    res.placed = 1'b1;
    res.x = POS_W'(fc * pitch);
    res.y = POS_W'(fr * pitch);
    return res;
  endfunction

  task automatic queue_rect(input int w, input int h, input int id, input bit drain);
    rect_t item;
    item.w = RECT_W'(w);
    item.h = RECT_W'(h);
    item.id = TAG_W'(id);
    item.drain = drain;
    pending_rects.push_back(item);
    rects_queued++;
  endtask

  function automatic int slots_to_px(input int n, input int pitch);
    int px;
    if (n == 0) return 0;
    px = (n - 1) * pitch + $urandom_range(1, pitch);
    return (px > RECT_MAX) ? RECT_MAX : px;
  endfunction

  // Mostly small rectangles sized to the current grid so that placements keep
  // coming; some large ones, and some raw words for noise.
  task automatic queue_random_rect(input bit drain);
    int pitch, cols, rows, kind, xs, ys;
    pitch = (slot_setting == 0) ? 1 : int'(slot_setting);
    cols = (cols_setting > GRID_COLS) ? GRID_COLS : int'(cols_setting);
    rows = (rows_setting > GRID_ROWS) ? GRID_ROWS : int'(rows_setting);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      queue_rect($urandom_range(0, RECT_MAX), $urandom_range(0, RECT_MAX),
                 $urandom_range(0, (1 << TAG_W) - 1), drain);
    end else begin
      if (kind == 1) begin
        xs = $urandom_range(0, cols + 1);
        ys = $urandom_range(0, rows + 1);
      end else begin
        xs = $urandom_range(1, (cols < 3) ? ((cols < 1) ? 1 : cols) : 3);
        ys = $urandom_range(1, (rows < 3) ? ((rows < 1) ? 1 : rows) : 3);
      end
      queue_rect(slots_to_px(xs, pitch), slots_to_px(ys, pitch),
                 $urandom_range(0, (1 << TAG_W) - 1), drain);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLUMNS: cols_setting = data[GRID_CFG_W-1:0];
      CFG_ROWS:    rows_setting = data[GRID_CFG_W-1:0];
      CFG_SLOT:    slot_setting = data[SLOT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (rects_taken != rects_queued || expected_spots.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] slot, input int count,
                           input bit tx_idle, input bit rx_idle, input int drain_at);
    int i;
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_SLOT, slot);
    send_idle_on <= tx_idle;
    recv_idle_on <= rx_idle;
    for (i = 0; i < count; i++) queue_random_rect(i == drain_at);
    wait_idle();
  endtask

  // Driver: presents one rectangle word at a time with random gaps.
  always @(posedge clk) begin
    rect_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_spots.push_back(place_rect(rect_width, rect_height, rect_id));
        rects_taken++;
        send_wait = idle_draw(send_idle_on);
      end
      if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_rects.size() != 0 &&
                   !(pending_rects[0].drain && (in_valid || expected_spots.size() != 0))) begin
        nxt = pending_rects.pop_front();
        rect_width  <= nxt.w;
        rect_height <= nxt.h;
        rect_id     <= nxt.id;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: takes placement words and checks them in order.
  always @(posedge clk) begin
    spot_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        spots_seen <= spots_seen + 1;
        if (expected_spots.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected placement word: placed %0b x %0d y %0d", placed, pos_x, pos_y);
          mismatches++;
        end else begin
          want = expected_spots.pop_front();
          if (placed !== want.placed || pos_x !== want.x || pos_y !== want.y) begin
            if (mismatches < 10)
              $display("placement %0d wrong: placed %0b/%0b x %0d/%0d y %0d/%0d (expected/actual)",
                       spots_seen, want.placed, placed, want.x, pos_x, want.y, pos_y);
            mismatches++;
          end
        end
        recv_wait = idle_draw(recv_idle_on);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (hold_left != 0) || (recv_wait != 0);
    end
  end

  // One long hold-off on the output so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && spots_seen >= HOLD_AFTER) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("grid_first_fit_rect_placer_top test failed");
      $finish;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_COLUMNS;
    cfg_data = '0;
    in_valid = 1'b0;
    rect_width = '0;
    rect_height = '0;
    rect_id = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    rects_queued = 0;
    rects_taken = 0;
    spots_seen = 0;
    mismatches = 0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    cols_setting = RST_COLUMNS;
    rows_setting = RST_ROWS;
    slot_setting = RST_SLOT;
    for (i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
      cell_taken[i] = 0;
      cell_owner[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset grid of 64 x 64 slots of 16 pixels.
    queue_rect(0, 0, 0, 0);          // zero size lands at the origin, marks nothing
    queue_rect(1, 1, 0, 0);          // id zero still takes its cell
    queue_rect(16, 16, 1023, 0);
    queue_rect(0, 5, 'h155, 0);      // zero width placed at origin though taken
    queue_rect(RECT_MAX, 1, 'h2AA, 0);
    queue_rect(1024, 16, 5, 0);      // full grid width
    queue_rect(1025, 1, 6, 0);
    queue_rect(4096, 4096, 7, 1);
    queue_rect(16, 1024, 8, 0);      // full grid height
    queue_rect(16, 1008, 9, 0);
    queue_rect(33, 17, 10, 0);
    queue_rect(17, 33, 11, 0);
    queue_rect(1, RECT_MAX, 12, 0);
    queue_rect(4096, 0, 13, 0);      // zero height but too wide
    queue_rect(1008, 16, 14, 0);
    queue_rect(48, 48, 15, 0);
    queue_rect(16, 16, 0, 0);
    queue_rect(15, 15, 1023, 0);
    wait_idle();

    run_phase(8'd12, 8'd6, 8'd3, 20, 1'b1, 1'b1, -1);
    write_reg(CFG_UNUSED, 8'hFF);
    run_phase(8'd0, 8'd9, 8'd0, 4, 1'b1, 1'b1, -1);
    run_phase(8'd1, 8'd64, 8'd255, 10, 1'b0, 1'b0, -1);
    run_phase(8'hFF, 8'hA0, 8'd5, 30, 1'b1, 1'b1, 12);
    run_phase(8'd64, 8'd1, 8'd1, 10, 1'b1, 1'b0, -1);
    run_phase(8'd40, 8'hFF, 8'd7, 25, 1'b0, 1'b1, -1);
    run_phase(8'hC0, 8'd64, 8'd200, 25, 1'b1, 1'b1, -1);

    if (mismatches == 0)
      $display("grid_first_fit_rect_placer_top test passed");
    else
      $display("grid_first_fit_rect_placer_top test failed");
    $finish;
  end

endmodule
